[design/cau_pkg.sv]
package cau_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MAG = 3'd4
  } op_t;

  // decoded request class, at most one bit set
  typedef struct packed {
    logic is_add;
    logic is_sub;
    logic is_mul;
    logic is_div;
    logic is_mag;
  } cls_t;

  localparam int QDEPTH = 4;
  localparam int QPW    = 2;

endpackage

[design/cau_front.sv]
module cau_front #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_op,
  input  logic signed [DATA_WIDTH-1:0] in_x_re,
  input  logic signed [DATA_WIDTH-1:0] in_x_im,
  input  logic signed [DATA_WIDTH-1:0] in_y_re,
  input  logic signed [DATA_WIDTH-1:0] in_y_im,
  input  logic                         q_pop,
  output logic                         q_valid,
  output cau_pkg::cls_t                q_cls,
  output logic signed [DATA_WIDTH-1:0] q_x_re,
  output logic signed [DATA_WIDTH-1:0] q_x_im,
  output logic signed [DATA_WIDTH-1:0] q_y_re,
  output logic signed [DATA_WIDTH-1:0] q_y_im
);

  cau_pkg::cls_t               cls_nxt;
  cau_pkg::cls_t               cls_mem [0:cau_pkg::QDEPTH-1];
  logic signed [DATA_WIDTH-1:0] xr_mem [0:cau_pkg::QDEPTH-1];
  logic signed [DATA_WIDTH-1:0] xi_mem [0:cau_pkg::QDEPTH-1];
  logic signed [DATA_WIDTH-1:0] yr_mem [0:cau_pkg::QDEPTH-1];
  logic signed [DATA_WIDTH-1:0] yi_mem [0:cau_pkg::QDEPTH-1];
  logic [cau_pkg::QPW-1:0]     wptr_r, rptr_r;
  logic [cau_pkg::QPW:0]       count_r;
  logic                        push, pop;

  always_comb begin
    cls_nxt = '0;
    unique case (in_op)
      cau_pkg::OP_ADD: cls_nxt.is_add = 1'b1;
      cau_pkg::OP_SUB: cls_nxt.is_sub = 1'b1;
      cau_pkg::OP_MUL: cls_nxt.is_mul = 1'b1;
      cau_pkg::OP_DIV: cls_nxt.is_div = 1'b1;
      cau_pkg::OP_MAG: cls_nxt.is_mag = 1'b1;
      default:         cls_nxt = '0;
    endcase
  end

  assign in_ready = count_r != (cau_pkg::QPW+1)'(cau_pkg::QDEPTH);
  assign push     = in_valid && in_ready;
  assign q_valid  = count_r != '0;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      count_r <= count_r + (cau_pkg::QPW+1)'(push) - (cau_pkg::QPW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cls_mem[wptr_r] <= cls_nxt;
      xr_mem[wptr_r]  <= in_x_re;
      xi_mem[wptr_r]  <= in_x_im;
      yr_mem[wptr_r]  <= in_y_re;
      yi_mem[wptr_r]  <= in_y_im;
    end
  end

  assign q_cls  = cls_mem[rptr_r];
  assign q_x_re = xr_mem[rptr_r];
  assign q_x_im = xi_mem[rptr_r];
  assign q_y_re = yr_mem[rptr_r];
  assign q_y_im = yi_mem[rptr_r];

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (cau_pkg::QPW+1)'(cau_pkg::QDEPTH))
    else $error("queue count beyond depth");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count missed a push");
`endif

endmodule

[design/cau_back.sv]
module cau_back #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  cau_pkg::cls_t                q_cls,
  input  logic signed [DATA_WIDTH-1:0] q_x_re,
  input  logic signed [DATA_WIDTH-1:0] q_x_im,
  input  logic signed [DATA_WIDTH-1:0] q_y_re,
  input  logic signed [DATA_WIDTH-1:0] q_y_im,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_z_re,
  output logic signed [DATA_WIDTH-1:0] out_z_im,
  output logic                         out_div_zero,
  output logic                         out_overflow
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 2;
  localparam int DB = 2 * W + 1;
  localparam int RB = 3 * W + 2 + FRAC_BITS;

  logic en;

  // operand stage
  logic                v0_r;
  cau_pkg::cls_t       c0_r;
  logic signed [W-1:0] xr0_r, xi0_r, yr0_r, yi0_r;

  // product stage
  logic                v1_r, dz1_r, dz1_nxt;
  cau_pkg::cls_t       c1_r;
  logic signed [PW-1:0] pa1_r, pb1_r, pri1_r, pir1_r, py1_r, py2_r;
  logic signed [PW-1:0] pa_nxt, pb_nxt, pri_nxt, pir_nxt, py1_nxt, py2_nxt;
  logic signed [W:0]    asr1_r, asi1_r, asr_nxt, asi_nxt;

  // sum stage
  logic                 v2_r, dz2_r;
  cau_pkg::cls_t        c2_r;
  logic signed [SW-1:0] sr2_r, si2_r, sr_nxt, si_nxt;
  logic [DB-1:0]        d2_r, d_nxt;

  // magnitude stage results
  logic [SW-1:0] magr, magi, valr_nxt, vali_nxt;
  logic [RB-1:0] remr_nxt, remi_nxt, dw;
  logic          negr, negi;

  // divider pipeline, index 0 is the magnitude stage
  logic                vld_r [0:W];
  cau_pkg::cls_t       c_r   [0:W];
  logic                dz_r  [0:W];
  logic [DB-1:0]       d_r   [0:W];
  logic [RB-1:0]       rr_r  [0:W];
  logic [RB-1:0]       ri_r  [0:W];
  logic [W-1:0]        qr_r  [0:W];
  logic [W-1:0]        qi_r  [0:W];
  logic [SW-1:0]       vr_r  [0:W];
  logic [SW-1:0]       vi_r  [0:W];
  logic                nr_r  [0:W];
  logic                ni_r  [0:W];
  logic                br_r  [0:W];
  logic                bi_r  [0:W];

  // output register
  logic                out_valid_r, out_div_zero_r, out_overflow_r;
  logic signed [W-1:0] out_z_re_r, out_z_im_r;
  logic [W:0]          satr, sati;
  logic [SW-1:0]       finr, fini;

  function automatic logic [W:0] sat(input logic [SW-1:0] v, input logic neg,
                                     input logic big);
    logic [SW-1:0] lim;
    logic          o;
    logic [W-1:0]  m;
    lim = neg ? (SW'(1) << (W - 1)) : ((SW'(1) << (W - 1)) - SW'(1));
    o   = big || (v > lim);
    m   = o ? lim[W-1:0] : v[W-1:0];
    sat = {o, (neg ? (W'(0) - m) : m)};
  endfunction

  assign en    = !out_valid_r || out_ready;
  assign q_pop = en && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      vld_r[0]    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v0_r        <= q_valid;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      vld_r[0]    <= v2_r;
      out_valid_r <= vld_r[W];
    end
  end

  // products, squares of x replace x*y for the magnitude request
  always_comb begin
    pa_nxt  = PW'(xr0_r) * PW'(c0_r.is_mag ? xr0_r : yr0_r);
    pb_nxt  = PW'(xi0_r) * PW'(c0_r.is_mag ? xi0_r : yi0_r);
    pri_nxt = PW'(xr0_r) * PW'(yi0_r);
    pir_nxt = PW'(xi0_r) * PW'(yr0_r);
    py1_nxt = PW'(yr0_r) * PW'(yr0_r);
    py2_nxt = PW'(yi0_r) * PW'(yi0_r);
    asr_nxt = c0_r.is_sub ? ((W+1)'(xr0_r) - (W+1)'(yr0_r))
                          : ((W+1)'(xr0_r) + (W+1)'(yr0_r));
    asi_nxt = c0_r.is_sub ? ((W+1)'(xi0_r) - (W+1)'(yi0_r))
                          : ((W+1)'(xi0_r) + (W+1)'(yi0_r));
    dz1_nxt = c0_r.is_div && (yr0_r == '0) && (yi0_r == '0);
  end

  always_comb begin
    sr_nxt = '0;
    si_nxt = '0;
    if (c1_r.is_add || c1_r.is_sub) begin
      sr_nxt = SW'(asr1_r);
      si_nxt = SW'(asi1_r);
    end else if (c1_r.is_mul) begin
      sr_nxt = SW'(pa1_r) - SW'(pb1_r);
      si_nxt = SW'(pri1_r) + SW'(pir1_r);
    end else if (c1_r.is_div) begin
      sr_nxt = SW'(pa1_r) + SW'(pb1_r);
      si_nxt = SW'(pir1_r) - SW'(pri1_r);
    end else if (c1_r.is_mag) begin
      sr_nxt = SW'(pa1_r) + SW'(pb1_r);
    end
    d_nxt = DB'($unsigned(py1_r)) + DB'($unsigned(py2_r));
  end

  // sign and magnitude, rescale truncates toward zero
  always_comb begin
    negr     = sr2_r[SW-1];
    negi     = si2_r[SW-1];
    magr     = negr ? $unsigned(-sr2_r) : $unsigned(sr2_r);
    magi     = negi ? $unsigned(-si2_r) : $unsigned(si2_r);
    valr_nxt = (c2_r.is_mul || c2_r.is_mag) ? (magr >> FRAC_BITS) : magr;
    vali_nxt = (c2_r.is_mul || c2_r.is_mag) ? (magi >> FRAC_BITS) : magi;
    remr_nxt = RB'(magr) << FRAC_BITS;
    remi_nxt = RB'(magi) << FRAC_BITS;
    dw       = RB'(d2_r) << W;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0_r   <= q_cls;
      xr0_r  <= q_x_re;
      xi0_r  <= q_x_im;
      yr0_r  <= q_y_re;
      yi0_r  <= q_y_im;

      c1_r   <= c0_r;
      dz1_r  <= dz1_nxt;
      pa1_r  <= pa_nxt;
      pb1_r  <= pb_nxt;
      pri1_r <= pri_nxt;
      pir1_r <= pir_nxt;
      py1_r  <= py1_nxt;
      py2_r  <= py2_nxt;
      asr1_r <= asr_nxt;
      asi1_r <= asi_nxt;

      c2_r   <= c1_r;
      dz2_r  <= dz1_r;
      sr2_r  <= sr_nxt;
      si2_r  <= si_nxt;
      d2_r   <= d_nxt;

      c_r[0]  <= c2_r;
      dz_r[0] <= dz2_r;
      d_r[0]  <= d2_r;
      rr_r[0] <= remr_nxt;
      ri_r[0] <= remi_nxt;
      qr_r[0] <= '0;
      qi_r[0] <= '0;
      vr_r[0] <= valr_nxt;
      vi_r[0] <= vali_nxt;
      nr_r[0] <= negr;
      ni_r[0] <= negi;
      // quotient would not fit in the data width
      br_r[0] <= remr_nxt >= dw;
      bi_r[0] <= remi_nxt >= dw;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 0; j < W; j++) begin : g_div
    localparam int K = W - 1 - j;
    logic [RB-1:0] dk;
    logic          ger, gei;

    assign dk  = RB'(d_r[j]) << K;
    assign ger = rr_r[j] >= dk;
    assign gei = ri_r[j] >= dk;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else if (en) begin
        vld_r[j+1] <= vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c_r[j+1]  <= c_r[j];
        dz_r[j+1] <= dz_r[j];
        d_r[j+1]  <= d_r[j];
        rr_r[j+1] <= ger ? (rr_r[j] - dk) : rr_r[j];
        ri_r[j+1] <= gei ? (ri_r[j] - dk) : ri_r[j];
        qr_r[j+1] <= ger ? (qr_r[j] | (W'(1) << K)) : qr_r[j];
        qi_r[j+1] <= gei ? (qi_r[j] | (W'(1) << K)) : qi_r[j];
        vr_r[j+1] <= vr_r[j];
        vi_r[j+1] <= vi_r[j];
        nr_r[j+1] <= nr_r[j];
        ni_r[j+1] <= ni_r[j];
        br_r[j+1] <= br_r[j];
        bi_r[j+1] <= bi_r[j];
      end
    end
  end

  always_comb begin
    finr = c_r[W].is_div ? SW'(qr_r[W]) : vr_r[W];
    fini = c_r[W].is_div ? SW'(qi_r[W]) : vi_r[W];
    satr = sat(finr, nr_r[W], c_r[W].is_div && br_r[W]);
    sati = sat(fini, ni_r[W], c_r[W].is_div && bi_r[W]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dz_r[W]) begin
        out_z_re_r     <= '0;
        out_z_im_r     <= '0;
        out_div_zero_r <= 1'b1;
        out_overflow_r <= 1'b0;
      end else begin
        out_z_re_r     <= satr[W-1:0];
        out_z_im_r     <= sati[W-1:0];
        out_div_zero_r <= 1'b0;
        out_overflow_r <= satr[W] || sati[W];
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_z_re     = out_z_re_r;
  assign out_z_im     = out_z_im_r;
  assign out_div_zero = out_div_zero_r;
  assign out_overflow = out_overflow_r;

`ifndef ASSERT_OFF
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_div_zero_r) |->
      (out_z_re_r == '0 && out_z_im_r == '0 && !out_overflow_r))
    else $error("zero divisor result not cleared");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[W] && !en) |=> vld_r[W])
    else $error("divider result dropped while stalled");
`endif

endmodule

[design/complex_arithmetic_unit.sv]
// complex add, subtract, multiply, divide and squared magnitude, signed fixed point
// path: queue, operand, product, sum, magnitude and divider stages, then the output register
// throughput: one request per cycle unless stalled; the restoring divider makes one quotient bit per stage
// a four-entry queue parts the front from the pipeline, which stalls as a whole on out_ready
// reset: synchronous, active low; clears queue pointers and all valid bits
module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_op,
  input  logic signed [DATA_WIDTH-1:0] in_x_re,
  input  logic signed [DATA_WIDTH-1:0] in_x_im,
  input  logic signed [DATA_WIDTH-1:0] in_y_re,
  input  logic signed [DATA_WIDTH-1:0] in_y_im,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_z_re,
  output logic signed [DATA_WIDTH-1:0] out_z_im,
  output logic                         out_div_zero,
  output logic                         out_overflow
);

  logic                         q_valid, q_pop;
  cau_pkg::cls_t                q_cls;
  logic signed [DATA_WIDTH-1:0] q_x_re, q_x_im, q_y_re, q_y_im;

  cau_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_op),
    .in_x_re  (in_x_re),
    .in_x_im  (in_x_im),
    .in_y_re  (in_y_re),
    .in_y_im  (in_y_im),
    .q_pop    (q_pop),
    .q_valid  (q_valid),
    .q_cls    (q_cls),
    .q_x_re   (q_x_re),
    .q_x_im   (q_x_im),
    .q_y_re   (q_y_re),
    .q_y_im   (q_y_im)
  );

  cau_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_cls        (q_cls),
    .q_x_re       (q_x_re),
    .q_x_im       (q_x_im),
    .q_y_re       (q_y_re),
    .q_y_im       (q_y_im),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_z_re     (out_z_re),
    .out_z_im     (out_z_im),
    .out_div_zero (out_div_zero),
    .out_overflow (out_overflow)
  );

endmodule
